FILE: hw/rtl/pfg_pkg.sv
// Shared types and constants for the playback fade/gap sequencer.
package pfg_pkg;

    localparam int FRAME_LEN = 64;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int PROD_W    = 16 + IDX_W;
    localparam int RECIP_W   = PROD_W + 2;
    localparam int MULT_W    = PROD_W + RECIP_W;

    // ramp-down/up divisor and first-ramp divisor
    localparam int DIV_A   = FRAME_LEN - 1;
    localparam int DIV_B   = FRAME_LEN - 2;
    localparam int SHIFT_A = PROD_W + $clog2(DIV_A);
    localparam int SHIFT_B = PROD_W + $clog2(DIV_B);

    localparam logic [63:0] RECIP_A_FULL =
        ((64'd1 << SHIFT_A) + 64'(DIV_A - 1)) / 64'(DIV_A);
    localparam logic [63:0] RECIP_B_FULL =
        ((64'd1 << SHIFT_B) + 64'(DIV_B - 1)) / 64'(DIV_B);
    localparam logic [RECIP_W-1:0] RECIP_A = RECIP_A_FULL[RECIP_W-1:0];
    localparam logic [RECIP_W-1:0] RECIP_B = RECIP_B_FULL[RECIP_W-1:0];

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    typedef enum logic [2:0] {
        ACT_START  = 3'd0,
        ACT_SAMPLE = 3'd1,
        ACT_EOS    = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_PAUSE  = 3'd4,
        ACT_RESUME = 3'd5,
        ACT_STOP   = 3'd6,
        ACT_TERM   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        MODE_FINISHED   = 3'd0,
        MODE_AWAIT      = 3'd1,
        MODE_NORMAL     = 3'd2,
        MODE_SILENCE    = 3'd3,
        MODE_GAP        = 3'd4,
        MODE_GAP_PAUSED = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        RAMP_FIRST = 2'd0,
        RAMP_DOWN  = 2'd1,
        RAMP_UP    = 2'd2,
        RAMP_ZERO  = 2'd3
    } t_ramp;

    typedef enum logic [1:0] {
        JOB_NONE   = 2'd0,
        JOB_SINGLE = 2'd1,
        JOB_FRAME  = 2'd2
    } t_job_kind;

    typedef enum logic [1:0] {
        END_NONE       = 2'd0,
        END_FINISHED   = 2'd1,
        END_STOPPED    = 2'd2,
        END_TERMINATED = 2'd3
    } t_reason;

    // work decoded from one input beat
    typedef struct packed {
        t_job_kind          kind;
        t_ramp              ramp;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               sval;
        t_reason            reason;
    } t_job;

    // one result in flight, before scaling
    typedef struct packed {
        logic               vld;
        logic               pass;
        logic               use_b;
        logic [IDX_W-1:0]   coef;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               sval;
        t_reason            reason;
        logic               last;
    } t_beat;

    typedef struct packed {
        logic               vld;
        logic               pass;
        logic               use_b;
        logic               neg_l;
        logic               neg_r;
        logic [PROD_W-1:0]  prod_l;
        logic [PROD_W-1:0]  prod_r;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               sval;
        t_reason            reason;
        logic               last;
    } t_prod_beat;

    typedef struct packed {
        logic               vld;
        logic               pass;
        logic               neg_l;
        logic               neg_r;
        logic [15:0]        quot_l;
        logic [15:0]        quot_r;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               sval;
        t_reason            reason;
        logic               last;
    } t_quot_beat;

endpackage

FILE: hw/rtl/pfg_seq.sv
// Playback mode sequencer: event decode, held sample, gap count, config register.
module pfg_seq import pfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_in_left,
    input  logic signed [15:0] i_in_right,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    output t_job               o_job
);

    t_mode              r_mode, n_mode;
    logic [15:0]        r_gap, n_gap;
    logic [15:0]        r_gap_frames;
    logic signed [15:0] r_held_l, n_held_l;
    logic signed [15:0] r_held_r, n_held_r;
    t_action            act;
    logic               active;
    logic [15:0]        gap_dec;
    logic [15:0]        gap_cfg_dec;

    assign act         = t_action'(i_action);
    assign active      = r_mode inside {MODE_AWAIT, MODE_NORMAL, MODE_SILENCE,
                                        MODE_GAP, MODE_GAP_PAUSED};
    assign gap_dec     = (r_gap != 16'd0) ? r_gap - 16'd1 : r_gap;
    assign gap_cfg_dec = (r_gap_frames != 16'd0) ? r_gap_frames - 16'd1 : 16'd0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_mode   = r_mode;
        n_gap    = r_gap;
        n_held_l = r_held_l;
        n_held_r = r_held_r;
        case (act)
            ACT_START: begin
                n_held_l = '0;
                n_held_r = '0;
                n_mode   = MODE_AWAIT;
            end
            ACT_STOP, ACT_TERM: begin
                if (active) n_mode = MODE_FINISHED;
            end
            ACT_SAMPLE: begin
                if (r_mode inside {MODE_AWAIT, MODE_NORMAL}) begin
                    n_held_l = i_in_left;
                    n_held_r = i_in_right;
                    n_mode   = MODE_NORMAL;
                end
            end
            ACT_EOS: begin
                if (r_mode inside {MODE_AWAIT, MODE_NORMAL}) begin
                    n_gap  = gap_cfg_dec;
                    n_mode = MODE_GAP;
                end
            end
            ACT_TICK: begin
                if (r_mode == MODE_GAP) begin
                    if (r_gap != 16'd0) n_gap = gap_dec;
                    else n_mode = MODE_FINISHED;
                end
            end
            ACT_PAUSE: begin
                if (r_mode == MODE_NORMAL) begin
                    n_mode = MODE_SILENCE;
                end else if (r_mode == MODE_GAP) begin
                    n_gap  = gap_dec;
                    n_mode = MODE_GAP_PAUSED;
                end
            end
            ACT_RESUME: begin
                if (r_mode == MODE_SILENCE) begin
                    n_mode = MODE_NORMAL;
                end else if (r_mode == MODE_GAP_PAUSED) begin
                    n_gap  = gap_dec;
                    n_mode = MODE_GAP;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_job        = '0;
        o_job.kind   = JOB_NONE;
        o_job.ramp   = RAMP_ZERO;
        o_job.sval   = 1'b1;
        o_job.reason = END_NONE;
        case (act)
            ACT_STOP, ACT_TERM: begin
                if (active) begin
                    o_job.kind   = JOB_SINGLE;
                    o_job.sval   = 1'b0;
                    o_job.reason = (act == ACT_STOP) ? END_STOPPED : END_TERMINATED;
                end
            end
            ACT_SAMPLE: begin
                o_job.left  = i_in_left;
                o_job.right = i_in_right;
                if (r_mode == MODE_AWAIT) begin
                    o_job.kind = JOB_FRAME;
                    o_job.ramp = RAMP_FIRST;
                end else if (r_mode == MODE_NORMAL) begin
                    o_job.kind = JOB_SINGLE;
                end
            end
            ACT_EOS: begin
                if (r_mode inside {MODE_AWAIT, MODE_NORMAL}) begin
                    o_job.kind  = JOB_FRAME;
                    o_job.ramp  = RAMP_DOWN;
                    o_job.left  = r_held_l;
                    o_job.right = r_held_r;
                end
            end
            ACT_TICK: begin
                if (r_mode inside {MODE_SILENCE, MODE_GAP_PAUSED}) begin
                    o_job.kind = JOB_FRAME;
                end else if (r_mode == MODE_GAP) begin
                    if (r_gap != 16'd0) begin
                        o_job.kind = JOB_FRAME;
                    end else begin
                        o_job.kind   = JOB_SINGLE;
                        o_job.sval   = 1'b0;
                        o_job.reason = END_FINISHED;
                    end
                end
            end
            ACT_PAUSE: begin
                if (r_mode == MODE_NORMAL) begin
                    o_job.kind  = JOB_FRAME;
                    o_job.ramp  = RAMP_DOWN;
                    o_job.left  = r_held_l;
                    o_job.right = r_held_r;
                end else if (r_mode == MODE_GAP) begin
                    o_job.kind = JOB_FRAME;
                end
            end
            ACT_RESUME: begin
                if (r_mode == MODE_SILENCE) begin
                    o_job.kind  = JOB_FRAME;
                    o_job.ramp  = RAMP_UP;
                    o_job.left  = r_held_l;
                    o_job.right = r_held_r;
                end else if (r_mode == MODE_GAP_PAUSED) begin
                    o_job.kind = JOB_FRAME;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_FINISHED;
            r_gap        <= '0;
            r_gap_frames <= '0;
            r_held_l     <= '0;
            r_held_r     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_gap_frames <= i_cfg_data;
            if (i_accept) begin
                r_mode   <= n_mode;
                r_gap    <= n_gap;
                r_held_l <= n_held_l;
                r_held_r <= n_held_r;
            end
        end
    end

endmodule

FILE: hw/rtl/pfg_gen.sv
// Frame generator: walks the sample index of a ramp or silence frame, or passes a single beat.
module pfg_gen import pfg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_accept,
    input  t_job  i_job,
    output logic  o_busy,
    output t_beat o_beat
);

    logic               r_busy, n_busy;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_ramp              r_ramp, n_ramp;
    logic signed [15:0] r_hl, n_hl;
    logic signed [15:0] r_hr, n_hr;
    t_beat              r_beat, n_beat;
    t_beat              single_beat;

    function automatic t_beat frame_beat(t_ramp ramp, logic [IDX_W-1:0] idx,
                                         logic signed [15:0] hl,
                                         logic signed [15:0] hr);
        t_beat b;
        b        = '0;
        b.vld    = 1'b1;
        b.sval   = 1'b1;
        b.reason = END_NONE;
        b.left   = hl;
        b.right  = hr;
        b.last   = (idx == LAST_IDX);
        case (ramp)
            RAMP_FIRST: begin
                if (idx == LAST_IDX) begin
                    b.pass = 1'b1;
                end else begin
                    b.coef  = idx;
                    b.use_b = 1'b1;
                end
            end
            RAMP_DOWN: b.coef = LAST_IDX - idx;
            RAMP_UP:   b.coef = idx;
            default: begin
                b.pass  = 1'b1;
                b.left  = '0;
                b.right = '0;
            end
        endcase
        return b;
    endfunction

    always_comb begin
        single_beat        = '0;
        single_beat.vld    = 1'b1;
        single_beat.pass   = 1'b1;
        single_beat.left   = i_job.sval ? i_job.left : 16'sd0;
        single_beat.right  = i_job.sval ? i_job.right : 16'sd0;
        single_beat.sval   = i_job.sval;
        single_beat.reason = i_job.reason;
        single_beat.last   = 1'b1;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_ramp = r_ramp;
        n_hl   = r_hl;
        n_hr   = r_hr;
        n_beat = '0;
        if (r_busy) begin
            n_beat = frame_beat(r_ramp, r_idx, r_hl, r_hr);
            n_idx  = r_idx + IDX_W'(1);
            if (r_idx == LAST_IDX) n_busy = 1'b0;
        end else if (i_accept && i_job.kind == JOB_FRAME) begin
            n_beat = frame_beat(i_job.ramp, '0, i_job.left, i_job.right);
            n_idx  = IDX_W'(1);
            n_busy = 1'b1;
            n_ramp = i_job.ramp;
            n_hl   = i_job.left;
            n_hr   = i_job.right;
        end else if (i_accept && i_job.kind == JOB_SINGLE) begin
            n_beat = single_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ramp <= RAMP_ZERO;
            r_hl   <= '0;
            r_hr   <= '0;
            r_beat <= '0;
        end else if (i_adv) begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ramp <= n_ramp;
            r_hl   <= n_hl;
            r_hr   <= n_hr;
            r_beat <= n_beat;
        end
    end

    assign o_busy = r_busy;
    assign o_beat = r_beat;

    a_frame_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_adv |=> r_beat.vld)
        else $error("frame beat dropped while generating");

    a_frame_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_job.kind == JOB_FRAME |=> r_busy && r_beat.vld && !r_beat.last)
        else $error("frame did not start after accept");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_adv |=> r_busy && $stable(r_idx))
        else $error("frame index moved during stall");

endmodule

FILE: hw/rtl/pfg_scale.sv
// Scaling pipeline: magnitude product, reciprocal divide, sign and output register.
module pfg_scale import pfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_beat              i_beat,
    output logic               o_out_valid,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic               o_sample_valid,
    output logic [1:0]         o_end_reason,
    output logic               o_last_of_run
);

    t_prod_beat         r_b, n_b;
    t_quot_beat         r_c, n_c;
    logic               r_out_vld;
    logic signed [15:0] r_out_l, r_out_r, n_out_l, n_out_r;
    logic               r_out_sval;
    t_reason            r_out_reason;
    logic               r_out_last;
    logic [15:0]        abs_l, abs_r;
    logic [RECIP_W-1:0] recip;
    logic [MULT_W-1:0]  mult_l, mult_r;

    assign abs_l = i_beat.left[15]  ? 16'(-i_beat.left)  : 16'(i_beat.left);
    assign abs_r = i_beat.right[15] ? 16'(-i_beat.right) : 16'(i_beat.right);

    always_comb begin
        n_b        = '0;
        n_b.vld    = i_beat.vld;
        n_b.pass   = i_beat.pass;
        n_b.use_b  = i_beat.use_b;
        n_b.neg_l  = i_beat.left[15];
        n_b.neg_r  = i_beat.right[15];
        n_b.prod_l = PROD_W'(abs_l) * PROD_W'(i_beat.coef);
        n_b.prod_r = PROD_W'(abs_r) * PROD_W'(i_beat.coef);
        n_b.left   = i_beat.left;
        n_b.right  = i_beat.right;
        n_b.sval   = i_beat.sval;
        n_b.reason = i_beat.reason;
        n_b.last   = i_beat.last;
    end

    // exact floor division by the frame divisor via rounded-up reciprocal
    assign recip  = r_b.use_b ? RECIP_B : RECIP_A;
    assign mult_l = MULT_W'(r_b.prod_l) * MULT_W'(recip);
    assign mult_r = MULT_W'(r_b.prod_r) * MULT_W'(recip);

    always_comb begin
        n_c        = '0;
        n_c.vld    = r_b.vld;
        n_c.pass   = r_b.pass;
        n_c.neg_l  = r_b.neg_l;
        n_c.neg_r  = r_b.neg_r;
        n_c.quot_l = r_b.use_b ? mult_l[SHIFT_B +: 16] : mult_l[SHIFT_A +: 16];
        n_c.quot_r = r_b.use_b ? mult_r[SHIFT_B +: 16] : mult_r[SHIFT_A +: 16];
        n_c.left   = r_b.left;
        n_c.right  = r_b.right;
        n_c.sval   = r_b.sval;
        n_c.reason = r_b.reason;
        n_c.last   = r_b.last;
    end

    always_comb begin
        if (r_c.pass) begin
            n_out_l = r_c.left;
            n_out_r = r_c.right;
        end else begin
            n_out_l = r_c.neg_l ? signed'(16'(-r_c.quot_l)) : signed'(r_c.quot_l);
            n_out_r = r_c.neg_r ? signed'(16'(-r_c.quot_r)) : signed'(r_c.quot_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b       <= '0;
            r_c       <= '0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_b       <= n_b;
            r_c       <= n_c;
            r_out_vld <= r_c.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_l      <= n_out_l;
            r_out_r      <= n_out_r;
            r_out_sval   <= r_c.sval;
            r_out_reason <= r_c.reason;
            r_out_last   <= r_c.last;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_left     = r_out_l;
    assign o_out_right    = r_out_r;
    assign o_sample_valid = r_out_sval;
    assign o_end_reason   = r_out_reason;
    assign o_last_of_run  = r_out_last;

endmodule

FILE: hw/rtl/playback_fade_gap_sequencer_top.sv
// Top level of the playback fade/gap sequencer.
//
//  channel  direction  handshake                    payload
//  in       to block   i_in_valid / o_in_ready      i_action, i_in_left, i_in_right
//  out      from block o_out_valid / i_out_ready    o_out_left, o_out_right,
//                                                   o_sample_valid, o_end_reason,
//                                                   o_last_of_run
//  cfg      to block   i_cfg_valid / o_cfg_ready    i_cfg_data (gap_frames)
//
// Pass-through samples and end markers are taken one input beat per cycle while the output does not stall.
// Ramp and silence frames put out FRAME_LEN results from the frame index counter, one per
// cycle while the output does not stall; the input is held off for the rest of the frame.
// After its beat is taken, a result passes the generator, product, divide and output
// registers in that order; an output stall can hold it at any of them.
// Synchronous active-low reset, no clearing pass.
// An output stall freezes the whole pipeline; the cfg port is always ready.
module playback_fade_gap_sequencer_top import pfg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_in_left,
    input  logic signed [15:0] i_in_right,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_left,
    output logic signed [15:0] o_out_right,
    output logic               o_sample_valid,
    output logic [1:0]         o_end_reason,
    output logic               o_last_of_run,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    logic  adv;
    logic  accept;
    logic  busy;
    t_job  job;
    t_beat beat;

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv && !busy;
    assign accept     = i_in_valid && o_in_ready;

    pfg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_in_left   (i_in_left),
        .i_in_right  (i_in_right),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job       (job)
    );

    pfg_gen u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_job    (job),
        .o_busy   (busy),
        .o_beat   (beat)
    );

    pfg_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_beat         (beat),
        .o_out_valid    (o_out_valid),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .o_sample_valid (o_sample_valid),
        .o_end_reason   (o_end_reason),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
